>>> rtl/tkct_pkg.sv
// Package for the TTL keyed cache table: opcodes, status codes, FSM states
// and the request and response word types.
// No dependencies; the top level ttl_keyed_cache_table imports it, tkct_ram does not.
package tkct_pkg;

  localparam int unsigned KEY_W     = 64;
  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned TTL_W     = 16;
  localparam logic [15:0] TTL_RESET = 16'd60;

  typedef enum logic [1:0] {
    OP_STORE  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_INVAL  = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_EXPIRED = 2'd2
  } st_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } fsm_e;

  typedef struct packed {
    op_e                opcode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } tkct_req_t;

  typedef struct packed {
    st_e                status;
    logic [VALUE_W-1:0] read_value;
    logic [SLOT_W-1:0]  slot;
  } tkct_rsp_t;

endpackage

>>> rtl/ttl_keyed_cache_table.sv
// Top level of the TTL keyed cache table: sequencer, scan unit and entry store.
// Depends on tkct_pkg and tkct_ram.
//
// A fully associative key/value table whose entries carry a time stamp.
// A request word (opcode, key, value) is taken on a clock edge where start is
// high and busy is low. Store writes or refreshes an entry, lookup returns the
// value of a live entry, invalidate clears an entry and tick advances the
// seconds counter that stamps and ages the entries.
// Exactly one response word follows each request. It stays on rsp_o and is
// marked by done_o for one cycle; the receiver cannot stall it, so it must take it.
// A tick is answered from the idle state, with no scan. Store, lookup and
// invalidate walk every entry once through the read port of the entry RAM
// and then, for a store or an entry to drop, write back through its write
// port: the response follows the scan, and busy stays high until the cycle of done_o.
// The ttl register is written through cfg_we_i / cfg_wdata_i and should only
// change while the block is idle; it resets to 60.
// After reset the block clears the valid bit of every entry, one entry a
// cycle, and busy stays high through that pass, before the first request.
module ttl_keyed_cache_table
  import tkct_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tkct_req_t        req_i,
  output logic             done_o,
  output tkct_rsp_t        rsp_o,
  input  logic             cfg_we_i,
  input  logic [TTL_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned EXT_W = IDX_W + SLOT_W;
  // Entry word layout: {valid, stamp, value, key}.
  localparam int unsigned VAL_LSB = KEY_BITS;
  localparam int unsigned STP_LSB = KEY_BITS + VALUE_BITS;
  localparam int unsigned WORD_W  = 1 + STAMP_W + VALUE_BITS + KEY_BITS;

  // Control state.
  fsm_e               state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               pend_q, pend_d;
  logic               found_q, found_d;
  logic               free_q, free_d;
  logic [STAMP_W-1:0] now_q, now_d;
  logic [TTL_W-1:0]   ttl_q;
  logic               done_q, done_d;

  // Payload state.
  op_e                 op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [IDX_W-1:0]    pidx_q, pidx_d;
  logic [IDX_W-1:0]    midx_q, midx_d;
  logic [VALUE_BITS-1:0] mval_q, mval_d;
  logic [STAMP_W-1:0]  mage_q, mage_d;
  logic [IDX_W-1:0]    fidx_q, fidx_d;
  logic [IDX_W-1:0]    bidx_q, bidx_d;
  logic [STAMP_W-1:0]  bage_q, bage_d;
  tkct_rsp_t           rsp_q, rsp_d;

  // Entry RAM ports.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // Fields of the entry that the scan looks at this cycle.
  logic                  ent_valid;
  logic [KEY_BITS-1:0]   ent_key;
  logic [VALUE_BITS-1:0] ent_val;
  logic [STAMP_W-1:0]    ent_age;
  logic [IDX_W-1:0]      tgt_idx;
  logic [EXT_W-1:0]      slot_ext;

  tkct_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent_valid = ram_rdata[WORD_W-1];
  assign ent_key   = ram_rdata[KEY_BITS-1:0];
  assign ent_val   = ram_rdata[VAL_LSB +: VALUE_BITS];
  // The one shared subtractor: age of the entry now leaving the RAM.
  assign ent_age   = now_q - ram_rdata[STP_LSB +: STAMP_W];

  // A store goes to the matching entry, else the first free one, else the
  // oldest one.
  assign tgt_idx  = found_q ? midx_q : (free_q ? fidx_q : bidx_q);
  assign slot_ext = EXT_W'(tgt_idx);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    found_d   = found_q;
    free_d    = free_q;
    now_d     = now_q;
    done_d    = 1'b0;
    op_d      = op_q;
    key_d     = key_q;
    val_d     = val_q;
    midx_d    = midx_q;
    mval_d    = mval_q;
    mage_d    = mage_q;
    fidx_d    = fidx_q;
    bidx_d    = bidx_q;
    bage_d    = bage_q;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[IDX_W-1:0];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cnt_q[IDX_W-1:0];

    unique case (state_q)
      S_CLEAR: begin
        // Write an empty word into every entry after reset.
        ram_we = 1'b1;
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_d  = req_i.opcode;
          key_d = req_i.key[KEY_BITS-1:0];
          val_d = req_i.value[VALUE_BITS-1:0];
          if (req_i.opcode == OP_TICK) begin
            now_d  = now_q + STAMP_W'(1);
            done_d = 1'b1;
            rsp_d  = '{status: ST_OK, read_value: '0, slot: '0};
          end else begin
            cnt_d   = '0;
            found_d = 1'b0;
            free_d  = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Issue one read a cycle; the data of the previous read is checked
        // in the same cycle.
        if (cnt_q < CNT_W'(ENTRIES)) begin
          ram_re = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
        if (pend_q) begin
          if (ent_valid && (ent_key == key_q) && !found_q) begin
            found_d = 1'b1;
            midx_d  = pidx_q;
            mval_d  = ent_val;
            mage_d  = ent_age;
          end
          if (!ent_valid && !free_q) begin
            free_d = 1'b1;
            fidx_d = pidx_q;
          end
          if (ent_valid && ((pidx_q == '0) || (ent_age > bage_q))) begin
            bidx_d = pidx_q;
            bage_d = ent_age;
          end
        end
        if (cnt_q == CNT_W'(ENTRIES)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        rsp_d   = '{status: ST_MISS, read_value: '0, slot: '0};
        case (op_q)
          OP_STORE: begin
            ram_we    = 1'b1;
            ram_waddr = tgt_idx;
            ram_wdata = {1'b1, now_q, val_q, key_q};
            rsp_d     = '{status: ST_OK, read_value: '0, slot: slot_ext[SLOT_W-1:0]};
          end
          OP_LOOKUP: begin
            if (found_q) begin
              if (mage_q > STAMP_W'(ttl_q)) begin
                // Stale entry: drop it and report it expired.
                ram_we    = 1'b1;
                ram_waddr = midx_q;
                rsp_d     = '{status: ST_EXPIRED, read_value: '0,
                              slot: slot_ext[SLOT_W-1:0]};
              end else begin
                rsp_d = '{status: ST_OK, read_value: VALUE_W'(mval_q),
                          slot: slot_ext[SLOT_W-1:0]};
              end
            end
          end
          OP_INVAL: begin
            if (found_q) begin
              ram_we    = 1'b1;
              ram_waddr = midx_q;
              rsp_d     = '{status: ST_OK, read_value: '0, slot: slot_ext[SLOT_W-1:0]};
            end
          end
          default: begin
            rsp_d = '{status: ST_OK, read_value: '0, slot: '0};
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    pend_d = ram_re;
    pidx_d = ram_raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
      now_q   <= '0;
      ttl_q   <= TTL_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      free_q  <= free_d;
      now_q   <= now_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        ttl_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    val_q  <= val_d;
    pidx_q <= pidx_d;
    midx_q <= midx_d;
    mval_q <= mval_d;
    mage_q <= mage_d;
    fidx_q <= fidx_d;
    bidx_q <= bidx_d;
    bage_q <= bage_d;
    rsp_q  <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A response comes only from the finish step or from a tick taken while idle.
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == S_FINISH) ||
               ($past(start) && ($past(state_q) == S_IDLE) &&
                ($past(req_i.opcode) == OP_TICK)))
    else $error("response without a finished request");

  // The entry RAM is written only by the clearing pass and the finish step.
  a_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR) || (state_q == S_FINISH))
    else $error("entry RAM written outside clear or finish");

  // Scan reads stay inside the table.
  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (state_q == S_SCAN) && (cnt_q < CNT_W'(ENTRIES)))
    else $error("entry RAM read out of range");

  // A store always answers ok with a zero value.
  a_store_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (op_q == OP_STORE)) |-> (rsp_o.status == ST_OK) &&
                                       (rsp_o.read_value == '0))
    else $error("store answered with a bad status");

endmodule

>>> rtl/tkct_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tkct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
